@@ rtl/aen_pkg.sv @@
// ----------------------------------------------------------------------------
// aen_pkg
// Shared types and constants of the Accept-Encoding negotiator.
// ----------------------------------------------------------------------------
package aen_pkg;

  // ASCII codes used by the byte classifier
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LOW_Q = 8'h71;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Coding names, lower case
  localparam int unsigned GZIP_LEN = 4;
  localparam int unsigned IDEN_LEN = 8;
  localparam logic [7:0] LIT_GZIP [GZIP_LEN] = '{8'h67, 8'h7A, 8'h69, 8'h70};
  localparam logic [7:0] LIT_IDEN [IDEN_LEN] =
    '{8'h69, 8'h64, 8'h65, 8'h6E, 8'h74, 8'h69, 8'h74, 8'h79};

  // Name length counter saturates at its all-ones value
  localparam int unsigned NLEN_W = 4;
  localparam logic [NLEN_W-1:0] NLEN_MAX = '1;

  // Candidate mask bits
  localparam int unsigned CAND_GZIP = 0;
  localparam int unsigned CAND_IDEN = 1;
  localparam int unsigned CAND_STAR = 2;

  // Queue between classifier and token engine
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_NAME   = 2'd1,
    PH_PARAMS = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    PP_START  = 2'd0,
    PP_AFTERQ = 2'd1,
    PP_QVAL   = 2'd2,
    PP_OTHER  = 2'd3
  } ppos_e;

  typedef enum logic [2:0] {
    QV_START = 3'd0,
    QV_ZERO  = 3'd1,
    QV_FRAC  = 3'd2,
    QV_TAIL  = 3'd3,
    QV_BAD   = 3'd4
  } qv_e;

  typedef enum logic [1:0] {
    OC_UNSEEN = 2'd0,
    OC_OK     = 2'd1,
    OC_REJECT = 2'd2
  } oc_e;

  typedef enum logic [1:0] {
    CODEC_GZIP = 2'd0,
    CODEC_IDEN = 2'd1,
    CODEC_NONE = 2'd2
  } codec_e;

  // One classified header beat
  typedef struct packed {
    logic                has_byte;
    logic                is_last;
    logic                is_ws;
    logic                is_comma;
    logic                is_semi;
    logic                is_star;
    logic                is_q;
    logic                is_eq;
    logic                is_dot;
    logic                is_zero;
    logic [GZIP_LEN-1:0] gz_match;
    logic [IDEN_LEN-1:0] id_match;
  } item_t;

  // Result beat
  typedef struct packed {
    codec_e selected_codec;
    logic   id_allowed;
    logic   gz_allowed;
  } result_t;

endpackage

@@ rtl/aen_front.sv @@
// ----------------------------------------------------------------------------
// aen_front
// Byte classifier: folds case and decodes each header byte into the flags
// the token engine needs.
// ----------------------------------------------------------------------------
module aen_front
  import aen_pkg::*;
(
  input  logic [7:0] header_byte_i,
  input  logic       has_byte_i,
  input  logic       is_last_i,
  output item_t      item_o
);

  logic [7:0] lower;

  // ASCII case folding
  assign lower = (header_byte_i >= CH_UP_A && header_byte_i <= CH_UP_Z) ?
                 (header_byte_i | CASE_BIT) : header_byte_i;

  always_comb begin
    item_o.has_byte = has_byte_i;
    item_o.is_last  = is_last_i;
    item_o.is_ws    = (header_byte_i == CH_SPACE) || (header_byte_i == CH_TAB);
    item_o.is_comma = (header_byte_i == CH_COMMA);
    item_o.is_semi  = (header_byte_i == CH_SEMI);
    item_o.is_star  = (header_byte_i == CH_STAR);
    item_o.is_q     = (lower == CH_LOW_Q);
    item_o.is_eq    = (header_byte_i == CH_EQ);
    item_o.is_dot   = (header_byte_i == CH_DOT);
    item_o.is_zero  = (header_byte_i == CH_ZERO);
    // per-position name compare
    for (int i = 0; i < GZIP_LEN; i++) begin
      item_o.gz_match[i] = (lower == LIT_GZIP[i]);
    end
    for (int i = 0; i < IDEN_LEN; i++) begin
      item_o.id_match[i] = (lower == LIT_IDEN[i]);
    end
  end

endmodule

@@ rtl/aen_fifo.sv @@
// ----------------------------------------------------------------------------
// aen_fifo
// Short queue of classified beats between classifier and token engine.
// ----------------------------------------------------------------------------
module aen_fifo
  import aen_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t pop_item_o
);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/aen_back.sv @@
// ----------------------------------------------------------------------------
// aen_back
// Token engine: tracks coding name, parameters and q value per token, keeps
// the per-coding outcomes and resolves the result at end of header.
// ----------------------------------------------------------------------------
module aen_back
  import aen_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  item_t   item_i,
  output logic    pop_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_ready_i
);

  phase_e            ph_q, ph_d;
  logic [NLEN_W-1:0] nlen_q, nlen_d;
  logic [2:0]        cand_q, cand_d;
  ppos_e             ppos_q, ppos_d;
  qv_e               qv_q, qv_d;
  logic              qseen_q, qseen_d;
  oc_e               gz_oc_q, gz_oc_d;
  oc_e               id_oc_q, id_oc_d;
  oc_e               st_oc_q, st_oc_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic              ends;
  logic              fin;
  logic              qzero;
  oc_e               tok_oc;
  logic              g_ok, id_ok;

  assign ends  = !item_i.has_byte || item_i.is_last;
  // a result beat needs a free output register
  assign pop_o = valid_i && (!ends || !out_valid_q || res_ready_i);

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // per-beat state update
  always_comb begin
    ph_d        = ph_q;
    nlen_d      = nlen_q;
    cand_d      = cand_q;
    ppos_d      = ppos_q;
    qv_d        = qv_q;
    qseen_d     = qseen_q;
    gz_oc_d     = gz_oc_q;
    id_oc_d     = id_oc_q;
    st_oc_d     = st_oc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    fin         = 1'b0;
    qzero       = 1'b0;
    tok_oc      = OC_OK;
    g_ok        = 1'b0;
    id_ok       = 1'b0;

    if (pop_o) begin
      // byte processing; a comma only closes the token
      if (item_i.has_byte && !item_i.is_comma) begin
        if (ph_d == PH_SKIP && !item_i.is_ws) begin
          ph_d    = PH_NAME;
          nlen_d  = '0;
          cand_d  = 3'b111;
          ppos_d  = PP_START;
          qv_d    = QV_START;
          qseen_d = 1'b0;
        end
        if (ph_d == PH_NAME) begin
          if (item_i.is_semi || item_i.is_ws) begin
            ph_d   = PH_PARAMS;
            ppos_d = PP_START;
          end else begin
            if (!(nlen_d < NLEN_W'(GZIP_LEN) && item_i.gz_match[nlen_d[1:0]])) begin
              cand_d[CAND_GZIP] = 1'b0;
            end
            if (!(nlen_d < NLEN_W'(IDEN_LEN) && item_i.id_match[nlen_d[2:0]])) begin
              cand_d[CAND_IDEN] = 1'b0;
            end
            if (!(nlen_d == '0 && item_i.is_star)) begin
              cand_d[CAND_STAR] = 1'b0;
            end
            if (nlen_d != NLEN_MAX) begin
              nlen_d = nlen_d + 1'b1;
            end
          end
        end else if (ph_d == PH_PARAMS) begin
          if (item_i.is_semi) begin
            ppos_d = PP_START;
          end else begin
            case (ppos_d)
              PP_START: begin
                if (!item_i.is_ws) begin
                  ppos_d = item_i.is_q ? PP_AFTERQ : PP_OTHER;
                end
              end
              PP_AFTERQ: begin
                if (item_i.is_eq) begin
                  ppos_d  = PP_QVAL;
                  qseen_d = 1'b1;
                  qv_d    = QV_START;
                end else begin
                  ppos_d = PP_OTHER;
                end
              end
              PP_QVAL: begin
                case (qv_d)
                  QV_START: qv_d = item_i.is_ws ? QV_START :
                                   (item_i.is_zero ? QV_ZERO : QV_BAD);
                  QV_ZERO:  qv_d = item_i.is_ws ? QV_TAIL :
                                   (item_i.is_dot ? QV_FRAC : QV_BAD);
                  QV_FRAC:  qv_d = item_i.is_ws ? QV_TAIL :
                                   (item_i.is_zero ? QV_FRAC : QV_BAD);
                  QV_TAIL:  qv_d = item_i.is_ws ? QV_TAIL : QV_BAD;
                  default:  qv_d = QV_BAD;
                endcase
              end
              default: ;
            endcase
          end
        end
      end

      // token close on comma or at end of header
      fin = (item_i.has_byte && item_i.is_comma && ph_q != PH_SKIP) ||
            (ends && ph_d != PH_SKIP);
      qzero  = (qv_d == QV_ZERO) || (qv_d == QV_FRAC) || (qv_d == QV_TAIL);
      tok_oc = (qseen_d && qzero) ? OC_REJECT : OC_OK;
      if (fin) begin
        if (cand_d[CAND_GZIP] && nlen_d == NLEN_W'(GZIP_LEN)) begin
          gz_oc_d = tok_oc;
        end else if (cand_d[CAND_IDEN] && nlen_d == NLEN_W'(IDEN_LEN)) begin
          id_oc_d = tok_oc;
        end else if (cand_d[CAND_STAR] && nlen_d == NLEN_W'(1)) begin
          st_oc_d = tok_oc;
        end
      end
      if (fin || ends) begin
        ph_d    = PH_SKIP;
        nlen_d  = '0;
        cand_d  = 3'b111;
        ppos_d  = PP_START;
        qv_d    = QV_START;
        qseen_d = 1'b0;
      end

      // star resolution and result register load
      if (ends) begin
        g_ok  = (gz_oc_d == OC_OK) || (gz_oc_d == OC_UNSEEN && st_oc_d == OC_OK);
        id_ok = (id_oc_d == OC_OK) ||
                (id_oc_d == OC_UNSEEN && st_oc_d != OC_REJECT);
        out_d.gz_allowed     = g_ok;
        out_d.id_allowed     = id_ok;
        out_d.selected_codec = g_ok ? CODEC_GZIP : (id_ok ? CODEC_IDEN : CODEC_NONE);
        out_valid_d = 1'b1;
        gz_oc_d = OC_UNSEEN;
        id_oc_d = OC_UNSEEN;
        st_oc_d = OC_UNSEEN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_SKIP;
      nlen_q      <= '0;
      cand_q      <= 3'b111;
      ppos_q      <= PP_START;
      qv_q        <= QV_START;
      qseen_q     <= 1'b0;
      gz_oc_q     <= OC_UNSEEN;
      id_oc_q     <= OC_UNSEEN;
      st_oc_q     <= OC_UNSEEN;
      out_valid_q <= 1'b0;
    end else begin
      ph_q        <= ph_d;
      nlen_q      <= nlen_d;
      cand_q      <= cand_d;
      ppos_q      <= ppos_d;
      qv_q        <= qv_d;
      qseen_q     <= qseen_d;
      gz_oc_q     <= gz_oc_d;
      id_oc_q     <= id_oc_d;
      st_oc_q     <= st_oc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

@@ rtl/accept_encoding_negotiator.sv @@
// ----------------------------------------------------------------------------
// accept_encoding_negotiator
// Negotiates gzip / identity from an Accept-Encoding header byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the header value, one byte per beat in tdata. tuser is
//   has_byte: a beat with tuser low ends an empty or absent header and its
//   byte is ignored. tlast marks the final byte of the header.
//   m_axis carries one result beat per header, issued when the header ends.
// Path: the ending input beat is written to the queue when it is
//   accepted, then the token engine loads the output register, which
//   presents the result beat; later if earlier beats are still queued.
// Throughput: one input beat per cycle while the queue is not full; the
//   engine retires one queued beat per cycle unless a stalled result holds it.
// Reset: clears the token state, the per-coding outcomes, the queue and
//   the output valid; the block is ready for a new header right away.
// Stall: while m_axis_tready is low the result beat holds; bytes keep
//   flowing until an ending beat reaches the engine, then the two-entry
//   queue fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module accept_encoding_negotiator
  import aen_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] header_byte
  input  logic       s_axis_tuser,  // [0] has_byte
  input  logic       s_axis_tlast,  // is_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] gzip ok, [1] identity ok,
                                    // [3:2] selected_codec, [7:4] zero
);

  item_t   cls_item;
  item_t   q_item;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  assign s_axis_tready = !q_full;

  // byte classification
  aen_front u_front (
    .header_byte_i (s_axis_tdata),
    .has_byte_i    (s_axis_tuser),
    .is_last_i     (s_axis_tlast),
    .item_o        (cls_item)
  );

  // decoupling queue
  aen_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_item_i (cls_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  // token engine and result register
  aen_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0000, res.selected_codec, res.id_allowed,
                         res.gz_allowed};

endmodule

@@ rtl/aen_checker.sv @@
// ----------------------------------------------------------------------------
// aen_checker
// Port-level checks of the negotiator, bound to the top level.
// ----------------------------------------------------------------------------
module aen_checker
  import aen_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // gzip acceptable selects gzip
  a_sel_gzip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3:2] == CODEC_GZIP)
    else $error("gzip acceptable but not selected");

  // identity acceptable and gzip not acceptable selects identity
  a_sel_iden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] && m_axis_tdata[1]
      |-> m_axis_tdata[3:2] == CODEC_IDEN)
    else $error("identity fallback not selected");

  // nothing acceptable gives none, with the padding zero
  a_sel_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] && !m_axis_tdata[1]
      |-> m_axis_tdata[3:2] == CODEC_NONE && m_axis_tdata[7:4] == 4'b0000)
    else $error("bad result encoding");

endmodule

bind accept_encoding_negotiator aen_checker u_aen_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
